[hw/rtl/cas_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cas_pkg;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;

    // Largest supported pending backslash limit and the count width that covers it.
    localparam int MAX_PENDING_LIMIT = 60;
    localparam int CNT_W = $clog2(MAX_PENDING_LIMIT + 1);

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_BYTE,
        TAIL_DONE,
        TAIL_OVF
    } tail_t;

    // One command: an optional end mark, then a run of backslashes, then a tail result.
    typedef struct packed {
        logic             pre_end;
        logic [CNT_W-1:0] bs_cnt;
        tail_t            tail;
        logic [7:0]       tail_byte;
    } cmd_t;

endpackage

`default_nettype wire

[hw/rtl/cas_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module cas_front #(
    parameter int MAX_PENDING_BACKSLASHES = 31
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  ch,
    input  wire logic        q_full,
    output logic             q_push,
    output cas_pkg::cmd_t    q_cmd
);

    localparam int PEND_W = $clog2(MAX_PENDING_BACKSLASHES + 1);
    localparam int CW = cas_pkg::CNT_W;

    logic              quoted_reg, quoted_next;
    logic              space_run_reg, space_run_next;
    logic              quote_pend_reg, quote_pend_next;
    logic [PEND_W-1:0] pend_reg, pend_next;

    logic          accept;
    cas_pkg::cmd_t cmd;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        logic sep;
        logic proceed;
        logic inq_eff;

        sep             = (ch == cas_pkg::CH_SPACE) || (ch == cas_pkg::CH_TAB);
        proceed         = 1'b1;
        inq_eff         = quoted_reg;
        quoted_next     = quoted_reg;
        space_run_next  = space_run_reg;
        quote_pend_next = quote_pend_reg;
        pend_next       = pend_reg;
        cmd.pre_end     = 1'b0;
        cmd.bs_cnt      = '0;
        cmd.tail        = cas_pkg::TAIL_NONE;
        cmd.tail_byte   = cas_pkg::CH_NUL;

        if (quote_pend_reg)
        begin
            quote_pend_next = 1'b0;
            if (ch == cas_pkg::CH_QUOTE)
            begin
                cmd.tail      = cas_pkg::TAIL_BYTE;
                cmd.tail_byte = cas_pkg::CH_QUOTE;
                proceed       = 1'b0;
            end
            else
            begin
                inq_eff     = 1'b0;
                quoted_next = 1'b0;
            end
        end

        if (proceed && space_run_reg)
        begin
            if (sep)
            begin
                proceed = 1'b0;
            end
            else if (ch == cas_pkg::CH_NUL)
            begin
                cmd.tail        = cas_pkg::TAIL_DONE;
                quoted_next     = 1'b0;
                space_run_next  = 1'b0;
                quote_pend_next = 1'b0;
                pend_next       = '0;
                proceed         = 1'b0;
            end
            else
            begin
                cmd.pre_end    = 1'b1;
                space_run_next = 1'b0;
            end
        end

        if (proceed)
        begin
            if (ch == cas_pkg::CH_NUL)
            begin
                cmd.bs_cnt      = CW'(pend_reg);
                cmd.tail        = cas_pkg::TAIL_DONE;
                quoted_next     = 1'b0;
                space_run_next  = 1'b0;
                quote_pend_next = 1'b0;
                pend_next       = '0;
            end
            else if (sep && !inq_eff)
            begin
                cmd.bs_cnt     = CW'(pend_reg);
                pend_next      = '0;
                space_run_next = 1'b1;
            end
            else if (ch == cas_pkg::CH_BSLASH)
            begin
                if (pend_reg < PEND_W'(MAX_PENDING_BACKSLASHES))
                    pend_next = pend_reg + PEND_W'(1);
                else
                    cmd.tail = cas_pkg::TAIL_OVF;
            end
            else if (ch == cas_pkg::CH_QUOTE)
            begin
                cmd.bs_cnt = CW'(pend_reg >> 1);
                if (pend_reg[0])
                begin
                    cmd.tail      = cas_pkg::TAIL_BYTE;
                    cmd.tail_byte = cas_pkg::CH_QUOTE;
                end
                else if (inq_eff)
                    quote_pend_next = 1'b1;
                else
                    quoted_next = 1'b1;
                pend_next = '0;
            end
            else
            begin
                cmd.bs_cnt    = CW'(pend_reg);
                cmd.tail      = cas_pkg::TAIL_BYTE;
                cmd.tail_byte = ch;
                pend_next     = '0;
            end
        end
    end

    assign q_cmd  = cmd;
    assign q_push = accept &&
                    (cmd.pre_end || (cmd.bs_cnt != '0) || (cmd.tail != cas_pkg::TAIL_NONE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quoted_reg     <= 1'b0;
            space_run_reg  <= 1'b0;
            quote_pend_reg <= 1'b0;
            pend_reg       <= '0;
        end
        else if (accept)
        begin
            quoted_reg     <= quoted_next;
            space_run_reg  <= space_run_next;
            quote_pend_reg <= quote_pend_next;
            pend_reg       <= pend_next;
        end
    end

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= PEND_W'(MAX_PENDING_BACKSLASHES))
        else $error("pending backslash count above limit");

    a_quote_pend_quoted: assert property (@(posedge clk) disable iff (!rst_n)
        quote_pend_reg |-> quoted_reg)
        else $error("quote pending outside quotes");

    a_space_run_unquoted: assert property (@(posedge clk) disable iff (!rst_n)
        space_run_reg |-> (!quoted_reg && !quote_pend_reg))
        else $error("separator run open inside quotes");

endmodule

`default_nettype wire

[hw/rtl/cas_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module cas_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire cas_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output cas_pkg::cmd_t      head,
    output logic               empty
);

    localparam int DEPTH = cas_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cas_pkg::cmd_t      entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/cas_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module cas_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cas_pkg::cmd_t head,
    input  wire logic          empty,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         out_byte,
    output logic               arg_end,
    output logic               line_done,
    output logic               overflow,
    output logic               last
);

    localparam int CW = cas_pkg::CNT_W;

    cas_pkg::cmd_t work_reg, work_next;
    logic          busy_reg, busy_next;
    logic          valid_reg, valid_next;
    logic [7:0]    byte_reg, byte_next;
    logic          end_reg, end_next;
    logic          done_reg, done_next;
    logic          ovf_reg, ovf_next;
    logic          last_reg, last_next;

    cas_pkg::cmd_t src;
    cas_pkg::cmd_t rem;
    logic          advance;
    logic          have_src;
    logic          rem_empty;

    assign advance  = !valid_reg || out_ready;
    assign have_src = busy_reg || !empty;
    assign src      = busy_reg ? work_reg : head;

    // First result of the source command and what is left of it.
    always_comb
    begin
        rem       = src;
        byte_next = cas_pkg::CH_NUL;
        end_next  = 1'b0;
        done_next = 1'b0;
        ovf_next  = 1'b0;
        if (src.pre_end)
        begin
            rem.pre_end = 1'b0;
            end_next    = 1'b1;
        end
        else if (src.bs_cnt != '0)
        begin
            rem.bs_cnt = src.bs_cnt - CW'(1);
            byte_next  = cas_pkg::CH_BSLASH;
        end
        else
        begin
            rem.tail = cas_pkg::TAIL_NONE;
            case (src.tail)
                cas_pkg::TAIL_BYTE: byte_next = src.tail_byte;
                cas_pkg::TAIL_DONE:
                begin
                    end_next  = 1'b1;
                    done_next = 1'b1;
                end
                cas_pkg::TAIL_OVF: ovf_next = 1'b1;
                default: byte_next = cas_pkg::CH_NUL;
            endcase
        end
        rem_empty = !rem.pre_end && (rem.bs_cnt == '0) && (rem.tail == cas_pkg::TAIL_NONE);
        last_next = rem_empty;
    end

    always_comb
    begin
        pop        = 1'b0;
        busy_next  = busy_reg;
        work_next  = work_reg;
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = have_src;
            if (have_src)
            begin
                pop       = !busy_reg;
                busy_next = !rem_empty;
                work_next = rem;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        if (advance && have_src)
        begin
            byte_reg <= byte_next;
            end_reg  <= end_next;
            done_reg <= done_next;
            ovf_reg  <= ovf_next;
            last_reg <= last_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign arg_end   = end_reg;
    assign line_done = done_reg;
    assign overflow  = ovf_reg;
    assign last      = last_reg;

    a_busy_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (work_reg.pre_end || (work_reg.bs_cnt != '0) ||
                      (work_reg.tail != cas_pkg::TAIL_NONE)))
        else $error("back end busy with an exhausted command");

endmodule

`default_nettype wire

[hw/rtl/command_line_argument_splitter.sv]
// Channel   Direction  Width  Contents
// s_axis    in         8      tdata[7:0] = ch
// m_axis    out        8+3+1  tdata[7:0] = out_byte; tuser = arg_end, line_done, overflow;
//                             tlast = last
//
// The front end takes one byte per cycle while the command queue has room.
// The back end sends one result per cycle while m_axis_tready is high, a byte's results in turn;
// a backslash run flushed by one byte gives up to MAX_PENDING_BACKSLASHES + 1 results.
// A four-entry command queue sits between the two and the result is registered.
// Reset is asynchronous and clears all control state; either side may stall at any time.
`timescale 1ns / 1ps
`default_nettype none

module command_line_argument_splitter #(
    parameter int MAX_PENDING_BACKSLASHES = 31
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
    output logic [2:0]       m_axis_tuser,   // [0] arg_end, [1] line_done, [2] overflow
    output logic             m_axis_tlast
);

    cas_pkg::cmd_t push_cmd;
    cas_pkg::cmd_t head;
    logic          push;
    logic          full;
    logic          pop;
    logic          empty;

    cas_front #(
        .MAX_PENDING_BACKSLASHES(MAX_PENDING_BACKSLASHES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .ch       (s_axis_tdata),
        .q_full   (full),
        .q_push   (push),
        .q_cmd    (push_cmd)
    );

    cas_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    cas_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .arg_end   (m_axis_tuser[0]),
        .line_done (m_axis_tuser[1]),
        .overflow  (m_axis_tuser[2]),
        .last      (m_axis_tlast)
    );

endmodule

`default_nettype wire

[dv/tb_command_line_argument_splitter.sv]
`timescale 1ns / 1ps

typedef struct packed {
    logic [7:0] out_byte;
    logic       arg_end;
    logic       line_done;
    logic       overflow;
    logic       last;
} arg_beat_t;

class arg_split_scoreboard;
    int unsigned max_backslashes = 31;
    arg_beat_t   expected_beats[$];
    int          mismatches = 0;
    int          beat_index = 0;

    logic        quoted = 1'b0;
    int unsigned backslash_count = 0;
    logic        separator_run = 1'b0;
    logic        quote_waiting = 1'b0;

    task report(string msg);
        if (mismatches < 40)
        begin
            $display("MISMATCH at result %0d: %s", beat_index, msg);
        end
        mismatches++;
    endtask

    function void add_beat(logic [7:0] b, logic e, logic d, logic o);
        arg_beat_t beat;
        beat.out_byte  = b;
        beat.arg_end   = e;
        beat.line_done = d;
        beat.overflow  = o;
        beat.last      = 1'b0;
        expected_beats.push_back(beat);
    endfunction

    function void add_backslashes(int unsigned count);
        for (int unsigned i = 0; i < count; i++)
        begin
            add_beat(cas_pkg::CH_BSLASH, 1'b0, 1'b0, 1'b0);
        end
    endfunction

    function void clear_line();
        quoted          = 1'b0;
        backslash_count = 0;
        separator_run   = 1'b0;
        quote_waiting   = 1'b0;
    endfunction

    // Works out the beats that one accepted command line byte produces.
    function void note_byte(logic [7:0] ch);
        int        first;
        logic      is_sep;
        logic      handled;
        arg_beat_t tail;
        first   = expected_beats.size();
        is_sep  = (ch == cas_pkg::CH_SPACE) || (ch == cas_pkg::CH_TAB);
        handled = 1'b0;
        if (quote_waiting)
        begin
            quote_waiting = 1'b0;
            if (ch == cas_pkg::CH_QUOTE)
            begin
                add_beat(cas_pkg::CH_QUOTE, 1'b0, 1'b0, 1'b0);
                handled = 1'b1;
            end
            else
            begin
                quoted = 1'b0;
            end
        end
        if (!handled && separator_run)
        begin
            if (is_sep)
            begin
                handled = 1'b1;
            end
            else if (ch == cas_pkg::CH_NUL)
            begin
                add_beat(8'h00, 1'b1, 1'b1, 1'b0);
                clear_line();
                handled = 1'b1;
            end
            else
            begin
                add_beat(8'h00, 1'b1, 1'b0, 1'b0);
                separator_run = 1'b0;
            end
        end
        if (!handled)
        begin
            if (ch == cas_pkg::CH_NUL)
            begin
                add_backslashes(backslash_count);
                add_beat(8'h00, 1'b1, 1'b1, 1'b0);
                clear_line();
            end
            else if (is_sep && !quoted)
            begin
                add_backslashes(backslash_count);
                backslash_count = 0;
                separator_run   = 1'b1;
            end
            else if (ch == cas_pkg::CH_BSLASH)
            begin
                if (backslash_count < max_backslashes)
                begin
                    backslash_count++;
                end
                else
                begin
                    add_beat(8'h00, 1'b0, 1'b0, 1'b1);
                end
            end
            else if (ch == cas_pkg::CH_QUOTE)
            begin
                add_backslashes(backslash_count / 2);
                if (backslash_count % 2 == 1)
                begin
                    add_beat(cas_pkg::CH_QUOTE, 1'b0, 1'b0, 1'b0);
                end
                else if (quoted)
                begin
                    quote_waiting = 1'b1;
                end
                else
                begin
                    quoted = 1'b1;
                end
                backslash_count = 0;
            end
            else
            begin
                add_backslashes(backslash_count);
                backslash_count = 0;
                add_beat(ch, 1'b0, 1'b0, 1'b0);
            end
        end
        if (expected_beats.size() > first)
        begin
            tail      = expected_beats.pop_back();
            tail.last = 1'b1;
            expected_beats.push_back(tail);
        end
    endfunction

    task check_beat(logic [7:0] data, logic [2:0] user, logic lst);
        arg_beat_t want;
        if (expected_beats.size() == 0)
        begin
            report($sformatf("unexpected beat data=%02h user=%03b last=%0b", data, user, lst));
        end
        else
        begin
            want = expected_beats.pop_front();
            if (data !== want.out_byte)
            begin
                report($sformatf("out_byte %02h, expected %02h", data, want.out_byte));
            end
            if (user[0] !== want.arg_end)
            begin
                report($sformatf("arg_end %0b, expected %0b", user[0], want.arg_end));
            end
            if (user[1] !== want.line_done)
            begin
                report($sformatf("line_done %0b, expected %0b", user[1], want.line_done));
            end
            if (user[2] !== want.overflow)
            begin
                report($sformatf("overflow %0b, expected %0b", user[2], want.overflow));
            end
            if (lst !== want.last)
            begin
                report($sformatf("last %0b, expected %0b", lst, want.last));
            end
        end
        beat_index++;
    endtask
endclass

module tb_command_line_argument_splitter;

    localparam int MAX_BS   = 31;
    localparam int HOLD_LEN = 300;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;
    logic       m_axis_tlast;

    arg_split_scoreboard sb = new;

    int bytes_sent = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_asked = 0;
    int hold_seen = 0;
    int hold_left = 0;

    command_line_argument_splitter #(
        .MAX_PENDING_BACKSLASHES(MAX_BS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            sb.note_byte(s_axis_tdata);
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    // A long hold-off is counted here, apart from the random stalls.
    always @(posedge clk)
    begin
        if (hold_seen != hold_asked)
        begin
            hold_seen     <= hold_asked;
            hold_left     <= HOLD_LEN;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] ch);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i]);
        end
        send_byte(cas_pkg::CH_NUL);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_beats.size() > 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [7:0] pick_plain();
        logic [7:0] v;
        v = 8'($urandom_range(1, 255));
        if (v == cas_pkg::CH_SPACE || v == cas_pkg::CH_TAB || v == cas_pkg::CH_BSLASH ||
            v == cas_pkg::CH_QUOTE)
        begin
            v = 8'h78;
        end
        return v;
    endfunction

    task automatic send_separators();
        repeat ($urandom_range(1, 3))
        begin
            send_byte($urandom_range(1) ? cas_pkg::CH_SPACE : cas_pkg::CH_TAB);
        end
    endtask

    task automatic send_random_line();
        int words;
        int kind;
        int run;
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(1, 12))
            begin
                send_byte(8'($urandom_range(0, 255)));
            end
            send_byte(cas_pkg::CH_NUL);
            return;
        end
        if ($urandom_range(3) == 0)
        begin
            send_separators();
        end
        words = $urandom_range(0, 4);
        for (int w = 0; w < words; w++)
        begin
            if (w > 0)
            begin
                send_separators();
            end
            repeat ($urandom_range(1, 5))
            begin
                kind = $urandom_range(9);
                if (kind <= 4)
                begin
                    send_byte(pick_plain());
                end
                else if (kind <= 6)
                begin
                    send_byte(cas_pkg::CH_QUOTE);
                end
                else if (kind == 7)
                begin
                    send_byte($urandom_range(1) ? cas_pkg::CH_SPACE : cas_pkg::CH_TAB);
                end
                else
                begin
                    run = ($urandom_range(39) == 0) ? $urandom_range(30, 36)
                                                    : $urandom_range(1, 4);
                    repeat (run)
                    begin
                        send_byte(cas_pkg::CH_BSLASH);
                    end
                end
            end
        end
        if ($urandom_range(3) == 0)
        begin
            send_separators();
        end
        send_byte(cas_pkg::CH_NUL);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        int target;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = bytes_sent + count;
        while (bytes_sent < target)
        begin
            send_random_line();
        end
        wait_drain();
    endtask

    initial
    begin
        sb.max_backslashes = MAX_BS;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("");
        send_text(" a\\\tb ");
        send_text("\"x\"\"y");
        send_text("\\\\\"q\\\\\\\"");
        wait_drain();

        // The receiver holds off while a long backslash burst fills the block.
        hold_asked++;
        send_byte("p");
        repeat (33)
        begin
            send_byte(cas_pkg::CH_BSLASH);
        end
        send_text("q r");
        wait_drain();

        run_phase(0, 0, 60);
        run_phase(64, 0, 60);
        run_phase(0, 64, 60);
        run_phase(6, 6, 60);

        repeat (50) @(posedge clk);
        if (sb.expected_beats.size() > 0)
        begin
            sb.report($sformatf("%0d expected beats never arrived", sb.expected_beats.size()));
        end
        if (sb.mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
